/* rtl/tccs_pkg.sv */
// Shared types and constants for the text console cursor/scroll engine.
// No dependencies.
package tccs_pkg;

  localparam int unsigned DEF_NUM_COLS = 80;
  localparam int unsigned DEF_NUM_ROWS = 25;

  localparam logic       REQ_PUT      = 1'b0;
  localparam logic       REQ_READ     = 1'b1;
  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] BLANK_ATTR   = 8'h0F;

  typedef struct packed {
    logic [7:0] attr;
    logic [7:0] chr;
  } cell_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] char_code;
    logic [7:0] attribute;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } in_item_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
    logic       scrolled;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCROLL
  } st_e;

endpackage

/* rtl/tccs_cell_ram.sv */
// Screen cell storage: one write port, one registered read port.
// Depends on tccs_pkg.
module tccs_cell_ram import tccs_pkg::*; #(
  parameter int unsigned DEPTH = DEF_NUM_ROWS * DEF_NUM_COLS,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  cell_t         wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output cell_t         rdata_o
);

  cell_t mem_q [DEPTH];
  cell_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/tccs_ctrl.sv */
// Request sequencer: cursor, row ring offset, clear/blank sweep and result register.
// Depends on tccs_pkg; drives the ports of tccs_cell_ram.
module tccs_ctrl import tccs_pkg::*; #(
  parameter int unsigned NUM_COLS = DEF_NUM_COLS,
  parameter int unsigned NUM_ROWS = DEF_NUM_ROWS,
  localparam int unsigned DEPTH   = NUM_ROWS * NUM_COLS,
  localparam int unsigned AW      = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  in_item_t      req_i,
  output logic          busy_o,
  output logic          valid_o,
  output out_item_t     rsp_o,
  output logic          mem_we_o,
  output logic [AW-1:0] mem_waddr_o,
  output cell_t         mem_wdata_o,
  output logic          mem_re_o,
  output logic [AW-1:0] mem_raddr_o,
  input  cell_t         mem_rdata_i
);

  localparam int unsigned CW = $clog2(NUM_COLS);
  localparam int unsigned RW = $clog2(NUM_ROWS);
  localparam logic [RW:0]   ROWS_EXT = (RW+1)'(NUM_ROWS);
  localparam logic [RW-1:0] ROW_LAST = RW'(NUM_ROWS - 1);
  localparam logic [CW-1:0] COL_LAST = CW'(NUM_COLS - 1);
  localparam logic [AW-1:0] ADDR_LAST = AW'(DEPTH - 1);
  localparam logic [AW-1:0] ROW_SPAN  = AW'(NUM_COLS - 1);

  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] row,
                                             input logic [RW-1:0] top);
    logic [RW:0] sum;
    sum = {1'b0, row} + {1'b0, top};
    if (sum >= ROWS_EXT) begin
      sum = sum - ROWS_EXT;
    end
    return sum[RW-1:0];
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] prow,
                                              input logic [CW-1:0] col);
    return AW'(32'(prow) * NUM_COLS + 32'(col));
  endfunction

  st_e             state_q, state_d;
  logic [RW-1:0]   cur_row_q, cur_row_d;
  logic [CW-1:0]   cur_col_q, cur_col_d;
  logic [RW-1:0]   top_q, top_d;
  logic [AW-1:0]   sweep_addr_q, sweep_addr_d;
  logic [AW-1:0]   sweep_last_q, sweep_last_d;
  logic            valid_q, valid_d;
  out_item_t       rsp_q, rsp_d;

  logic            accept;
  logic            is_read;
  logic            rd_in_range;
  logic            rd_go;
  logic            is_nl;
  logic            row_adv;
  logic            row_last;
  logic            put_scroll;
  logic            sweep_end;
  logic [RW-1:0]   rd_row;
  logic [CW-1:0]   rd_col;
  logic [RW-1:0]   put_row;
  logic [CW-1:0]   put_col;
  logic [AW-1:0]   scroll_base;

  assign accept      = start_i && (state_q == ST_IDLE);
  assign is_read     = (req_i.req_type == REQ_READ);
  assign rd_in_range = (32'(req_i.read_row) < NUM_ROWS) && (32'(req_i.read_col) < NUM_COLS);
  assign rd_go       = accept && is_read && rd_in_range;
  assign rd_row      = RW'(32'(req_i.read_row));
  assign rd_col      = CW'(32'(req_i.read_col));
  assign is_nl       = (req_i.char_code == NEWLINE_CODE);
  assign row_adv     = is_nl || (cur_col_q == COL_LAST);
  assign row_last    = (cur_row_q == ROW_LAST);
  assign put_scroll  = row_adv && row_last;
  assign sweep_end   = (sweep_addr_q == sweep_last_q);
  assign scroll_base = cell_addr(top_q, '0);

  always_comb begin
    put_col = cur_col_q + CW'(1);
    put_row = cur_row_q;
    if (row_adv) begin
      put_col = '0;
      if (!row_last) begin
        put_row = cur_row_q + RW'(1);
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sweep_end) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (rd_go) begin
          state_d = ST_READ;
        end else if (accept && !is_read && put_scroll) begin
          state_d = ST_SCROLL;
        end
      end
      ST_READ: state_d = ST_IDLE;
      ST_SCROLL: begin
        if (sweep_end) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // memory control outputs
  always_comb begin
    busy_o      = (state_q != ST_IDLE);
    mem_we_o    = 1'b0;
    mem_waddr_o = sweep_addr_q;
    mem_wdata_o = '{attr: BLANK_ATTR, chr: BLANK_CHAR};
    mem_re_o    = rd_go;
    mem_raddr_o = cell_addr(phys_row(rd_row, top_q), rd_col);
    unique case (state_q)
      ST_CLEAR, ST_SCROLL: mem_we_o = 1'b1;
      ST_IDLE: begin
        if (accept && !is_read && !is_nl) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = cell_addr(phys_row(cur_row_q, top_q), cur_col_q);
          mem_wdata_o = '{attr: req_i.attribute, chr: req_i.char_code};
        end
      end
      ST_READ: mem_we_o = 1'b0;
      default: mem_we_o = 1'b0;
    endcase
  end

  // datapath next values
  always_comb begin
    cur_row_d    = cur_row_q;
    cur_col_d    = cur_col_q;
    top_d        = top_q;
    sweep_addr_d = sweep_addr_q;
    sweep_last_d = sweep_last_q;
    valid_d      = 1'b0;
    rsp_d        = rsp_q;
    unique case (state_q)
      ST_CLEAR, ST_SCROLL: sweep_addr_d = sweep_addr_q + AW'(1);
      ST_IDLE: begin
        if (accept) begin
          rsp_d.cell_char = '0;
          rsp_d.cell_attr = '0;
          rsp_d.scrolled  = 1'b0;
          if (is_read) begin
            rsp_d.cursor_row = 5'(32'(cur_row_q));
            rsp_d.cursor_col = 7'(32'(cur_col_q));
            valid_d          = !rd_in_range;
          end else begin
            cur_row_d        = put_row;
            cur_col_d        = put_col;
            rsp_d.cursor_row = 5'(32'(put_row));
            rsp_d.cursor_col = 7'(32'(put_col));
            rsp_d.scrolled   = put_scroll;
            valid_d          = 1'b1;
            if (put_scroll) begin
              sweep_addr_d = scroll_base;
              sweep_last_d = scroll_base + ROW_SPAN;
              top_d        = (top_q == ROW_LAST) ? '0 : top_q + RW'(1);
            end
          end
        end
      end
      ST_READ: begin
        rsp_d.cell_char = mem_rdata_i.chr;
        rsp_d.cell_attr = mem_rdata_i.attr;
        valid_d         = 1'b1;
      end
      default: valid_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      cur_row_q    <= '0;
      cur_col_q    <= '0;
      top_q        <= '0;
      sweep_addr_q <= '0;
      sweep_last_q <= ADDR_LAST;
      valid_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      cur_row_q    <= cur_row_d;
      cur_col_q    <= cur_col_d;
      top_q        <= top_d;
      sweep_addr_q <= sweep_addr_d;
      sweep_last_q <= sweep_last_d;
      valid_q      <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

/* rtl/text_console_cursor_scroll.sv */
// Top level of the text console engine: sequencer plus screen cell RAM.
// Depends on tccs_pkg, tccs_ctrl and tccs_cell_ram.
//
// An item is taken when start is high and busy is low; its result appears on rsp_o for one
// cycle with valid_o high and cannot be stalled. A put returns its result in the cycle after
// it is taken and, unless it scrolls, the next item may follow at once. A read of a cell on
// the screen goes through the registered read port of the cell RAM and then the result
// register, and holds busy for one cycle. A read outside the screen answers in the cycle
// after it is taken, like a put, without raising busy. A put that scrolls blanks one storage
// row through the single RAM write port and holds busy until that row is blank. After reset
// the RAM is blanked one cell per cycle, and busy stays high until every cell is blank.
module text_console_cursor_scroll import tccs_pkg::*; #(
  parameter int unsigned NUM_COLS = DEF_NUM_COLS,
  parameter int unsigned NUM_ROWS = DEF_NUM_ROWS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_item_t  req_i,
  output logic      valid_o,
  output out_item_t rsp_o
);

  localparam int unsigned DEPTH = NUM_ROWS * NUM_COLS;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  cell_t         mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  cell_t         mem_rdata;

  tccs_ctrl #(
    .NUM_COLS (NUM_COLS),
    .NUM_ROWS (NUM_ROWS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_i       (req_i),
    .busy_o      (busy),
    .valid_o     (valid_o),
    .rsp_o       (rsp_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  tccs_cell_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
